### src/tagged_handle_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Tagged handle slot allocator: assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef TAGGED_HANDLE_SLOT_ALLOCATOR_DEFINES_SVH
`define TAGGED_HANDLE_SLOT_ALLOCATOR_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define THSA_ASSERT_HOLD(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define THSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/thsa_pkg.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator package
// Types, codes and fixed widths shared by the allocator modules.
// ----------------------------------------------------------------------------
package thsa_pkg;

    localparam int C_POOLS      = 3;
    localparam int C_WORD_BITS  = 32;
    localparam int C_BIT_W      = 5;
    localparam int C_IDX_W      = 24;
    localparam int C_WIDX_W     = C_IDX_W - C_BIT_W;
    localparam int C_SIZE_W     = C_IDX_W + 1;
    localparam int C_TAG_W      = 8;
    localparam int C_HANDLE_W   = 32;
    localparam int C_SERIAL_W   = 32;
    localparam int C_SLOT_OUT_W = 9;
    localparam int C_CFG_IDX_W  = 2;

    localparam logic [C_TAG_W-1:0] C_SPRITE_TAG_RST = 8'd128;
    localparam logic [C_TAG_W-1:0] C_WINDOW_TAG_RST = 8'd129;
    localparam logic [C_TAG_W-1:0] C_GROUP_TAG_RST  = 8'd130;

    typedef enum logic [1:0] {
        OP_CREATE,
        OP_DESTROY,
        OP_RESOLVE,
        OP_CLEAR
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK,
        STS_UNKNOWN,
        STS_FULL,
        STS_EMPTY
    } t_status;

    typedef enum logic [1:0] {
        POOL_SPRITE,
        POOL_WINDOW,
        POOL_GROUP
    } t_pool;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_SPRITE_TAG,
        REG_WINDOW_TAG,
        REG_GROUP_TAG
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_ACCESS,
        ST_CLEAR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic decode;
        logic scan;
        logic access;
        logic clear;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic go_scan;
        logic go_access;
        logic go_clear;
        logic scan_found;
        logic clear_last;
        logic out_free;
    } t_dp_stat;

endpackage

### src/thsa_if.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator channels
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface thsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  kind_tag;
    logic [31:0] handle;

    modport source (output valid, opcode, kind_tag, handle, input ready);
    modport sink   (input valid, opcode, kind_tag, handle, output ready);
endinterface

interface thsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] new_handle;
    logic        is_screen;
    logic [1:0]  pool;
    logic [8:0]  slot_index;
    logic [31:0] slot_serial;

    modport source (output valid, status, new_handle, is_screen, pool, slot_index,
                    slot_serial, input ready);
    modport sink   (input valid, status, new_handle, is_screen, pool, slot_index,
                    slot_serial, output ready);
endinterface

interface thsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/tagged_handle_slot_allocator.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator
// Lowest-free slot allocation over sprite, window and group pools with
// tagged 32-bit handles, per-slot serial stamps and clear-all.
// ----------------------------------------------------------------------------
// One request is worked at a time. Destroy and resolve that reach a slot pass
// through decode, slot access and finish; for the screen handle, an unknown
// tag or an index out of range they go from decode straight to finish, as
// does a create that is refused (unknown tag or full pool); a create scans
// the pool's 32-slot occupancy words from its lowest word that may hold a
// free slot, one occupancy memory read per cycle, until a free slot is found.
// Clear-all zeroes every occupancy word, and reset is followed by such a
// clearing pass with no request accepted; the total occupancy word count is
// ceil(SPRITE_SLOTS/32) + ceil(WINDOW_SLOTS/32) + ceil(GROUP_SLOTS/32),
// 20 at the defaults. A result held back by the sink delays the next request.
// Register writes are taken in any cycle.
module tagged_handle_slot_allocator #(
    parameter int SPRITE_SLOTS = 512,
    parameter int WINDOW_SLOTS = 64,
    parameter int GROUP_SLOTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thsa_req_if.sink    i_req,
    thsa_rsp_if.source  o_rsp,
    thsa_cfg_if.sink    i_cfg
);
    import thsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    thsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    thsa_datapath #(
        .SPRITE_SLOTS (SPRITE_SLOTS),
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .GROUP_SLOTS  (GROUP_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_req.opcode),
        .i_kind_tag    (i_req.kind_tag),
        .i_handle      (i_req.handle),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_new_handle  (o_rsp.new_handle),
        .o_is_screen   (o_rsp.is_screen),
        .o_pool        (o_rsp.pool),
        .o_slot_index  (o_rsp.slot_index),
        .o_slot_serial (o_rsp.slot_serial)
    );

endmodule

### src/thsa_ctrl.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator controller
// Sequences init clear, decode, slot scan, slot access and result hand-off.
// ----------------------------------------------------------------------------
`include "tagged_handle_slot_allocator_defines.svh"

module thsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  thsa_pkg::t_dp_stat i_stat,
    output thsa_pkg::t_dp_cmd  o_cmd
);
    import thsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                priority if (i_stat.go_clear) n_state = ST_CLEAR;
                else if (i_stat.go_scan)      n_state = ST_SCAN;
                else if (i_stat.go_access)    n_state = ST_ACCESS;
                else                          n_state = ST_FINISH;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_found) n_state = ST_FINISH;
            end
            ST_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `THSA_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_req_valid && o_req_ready, r_state == ST_DECODE, "accepted request not decoded")
    `THSA_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, (r_state == ST_FINISH) && i_stat.out_free, r_state == ST_IDLE, "result loaded without return to idle")

endmodule

### src/thsa_datapath.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator datapath
// Tag registers, occupancy and serial memories, pool counters, result regs.
// ----------------------------------------------------------------------------
`include "tagged_handle_slot_allocator_defines.svh"

module thsa_datapath #(
    parameter int SPRITE_SLOTS = 512,
    parameter int WINDOW_SLOTS = 64,
    parameter int GROUP_SLOTS  = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  thsa_pkg::t_dp_cmd                    i_cmd,
    output thsa_pkg::t_dp_stat                   o_stat,
    input  logic [1:0]                           i_opcode,
    input  logic [thsa_pkg::C_TAG_W-1:0]         i_kind_tag,
    input  logic [thsa_pkg::C_HANDLE_W-1:0]      i_handle,
    input  logic                                 i_cfg_valid,
    input  logic [thsa_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [thsa_pkg::C_TAG_W-1:0]         i_cfg_data,
    input  logic                                 i_rsp_ready,
    output logic                                 o_rsp_valid,
    output logic [1:0]                           o_status,
    output logic [thsa_pkg::C_HANDLE_W-1:0]      o_new_handle,
    output logic                                 o_is_screen,
    output logic [1:0]                           o_pool,
    output logic [thsa_pkg::C_SLOT_OUT_W-1:0]    o_slot_index,
    output logic [thsa_pkg::C_SERIAL_W-1:0]      o_slot_serial
);
    import thsa_pkg::*;

    function automatic logic [C_WORD_BITS-1:0] last_mask(input int n);
        logic [C_WORD_BITS-1:0] m;
        for (int i = 0; i < C_WORD_BITS; i++) m[i] = (i < n);
        return m;
    endfunction

    function automatic logic [C_BIT_W-1:0] lowest_zero(input logic [C_WORD_BITS-1:0] w);
        logic [C_BIT_W-1:0] b;
        b = '0;
        for (int i = C_WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) b = C_BIT_W'(i);
        end
        return b;
    endfunction

    localparam int S_WORDS     = (SPRITE_SLOTS + C_WORD_BITS - 1) / C_WORD_BITS;
    localparam int W_WORDS     = (WINDOW_SLOTS + C_WORD_BITS - 1) / C_WORD_BITS;
    localparam int G_WORDS     = (GROUP_SLOTS + C_WORD_BITS - 1) / C_WORD_BITS;
    localparam int TOTAL_WORDS = S_WORDS + W_WORDS + G_WORDS;
    localparam int TOTAL_SLOTS = SPRITE_SLOTS + WINDOW_SLOTS + GROUP_SLOTS;
    localparam int WAW         = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int SAW         = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int MAX_SW      = (SPRITE_SLOTS > WINDOW_SLOTS) ? SPRITE_SLOTS : WINDOW_SLOTS;
    localparam int MAX_SLOTS   = (MAX_SW > GROUP_SLOTS) ? MAX_SW : GROUP_SLOTS;
    localparam int CW          = $clog2(MAX_SLOTS + 1);
    localparam int S_LAST      = SPRITE_SLOTS - C_WORD_BITS * (S_WORDS - 1);
    localparam int W_LAST      = WINDOW_SLOTS - C_WORD_BITS * (W_WORDS - 1);
    localparam int G_LAST      = GROUP_SLOTS - C_WORD_BITS * (G_WORDS - 1);

    localparam logic [C_POOLS-1:0][C_SIZE_W-1:0] P_SIZE = {
        C_SIZE_W'(GROUP_SLOTS), C_SIZE_W'(WINDOW_SLOTS), C_SIZE_W'(SPRITE_SLOTS)};
    localparam logic [C_POOLS-1:0][C_WIDX_W-1:0] P_LASTW = {
        C_WIDX_W'(G_WORDS - 1), C_WIDX_W'(W_WORDS - 1), C_WIDX_W'(S_WORDS - 1)};
    localparam logic [C_POOLS-1:0][WAW-1:0] P_WBASE = {
        WAW'(S_WORDS + W_WORDS), WAW'(S_WORDS), WAW'(0)};
    localparam logic [C_POOLS-1:0][SAW-1:0] P_SBASE = {
        SAW'(SPRITE_SLOTS + WINDOW_SLOTS), SAW'(SPRITE_SLOTS), SAW'(0)};
    localparam logic [C_POOLS-1:0][C_WORD_BITS-1:0] P_LMASK = {
        last_mask(G_LAST), last_mask(W_LAST), last_mask(S_LAST)};

    // tag registers and pool state
    logic [C_TAG_W-1:0]                  r_sprite_tag;
    logic [C_TAG_W-1:0]                  r_window_tag;
    logic [C_TAG_W-1:0]                  r_group_tag;
    logic [C_POOLS-1:0][CW-1:0]          r_count;
    logic [C_POOLS-1:0][C_SERIAL_W-1:0]  r_next;
    logic [C_POOLS-1:0][C_WIDX_W-1:0]    r_hint;
    logic [WAW-1:0]                      r_clr;

    // request context
    t_opcode                r_op;
    logic [C_HANDLE_W-1:0]  r_handle;
    t_pool                  r_pool;
    logic                   r_hit;
    logic [C_WIDX_W-1:0]    r_word;

    // memories
    logic [C_WORD_BITS-1:0] occ_mem [TOTAL_WORDS];
    logic [C_SERIAL_W-1:0]  ser_mem [TOTAL_SLOTS];
    logic [C_WORD_BITS-1:0] r_occ_rd;
    logic [C_SERIAL_W-1:0]  r_ser_rd;

    // result in progress and output stage
    t_status                  r_res_status;
    logic [C_HANDLE_W-1:0]    r_res_newh;
    logic                     r_res_screen;
    t_pool                    r_res_pool;
    logic [C_SLOT_OUT_W-1:0]  r_res_slot;
    logic [C_SERIAL_W-1:0]    r_res_serial;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [C_HANDLE_W-1:0]    r_out_newh;
    logic                     r_out_screen;
    t_pool                    r_out_pool;
    logic [C_SLOT_OUT_W-1:0]  r_out_slot;
    logic [C_SERIAL_W-1:0]    r_out_serial;

    logic [C_TAG_W-1:0]      in_tag;
    t_pool                   in_pool;
    logic                    in_hit;
    logic [C_TAG_W-1:0]      pool_tag;
    logic [C_IDX_W-1:0]      idx;
    logic                    screen;
    logic                    full;
    logic                    range_bad;
    t_status                 dec_status;
    t_pool                   dec_pool;
    logic [C_WIDX_W-1:0]     rd_widx;
    logic [WAW-1:0]          occ_raddr;
    logic [SAW-1:0]          ser_raddr;
    logic [C_WORD_BITS-1:0]  word_mask;
    logic [C_WORD_BITS-1:0]  eff_word;
    logic                    scan_found;
    logic [C_BIT_W-1:0]      free_bit;
    logic [C_IDX_W-1:0]      free_slot;
    logic                    slot_used;
    logic                    scan_commit;
    logic                    destroy_commit;
    logic                    occ_we;
    logic [WAW-1:0]          occ_waddr;
    logic [C_WORD_BITS-1:0]  occ_wdata;
    logic [C_BIT_W-1:0]      wbit;
    logic [C_WORD_BITS-1:0]  wbit_onehot;
    logic                    clear_last;
    logic                    out_free;

    // pool lookup on the incoming request, lowest pool wins on equal tags
    always_comb begin
        in_tag = (t_opcode'(i_opcode) == OP_CREATE) ? i_kind_tag
                                                    : i_handle[C_HANDLE_W-1 -: C_TAG_W];
        in_hit  = 1'b1;
        in_pool = POOL_SPRITE;
        priority if (in_tag == r_sprite_tag) in_pool = POOL_SPRITE;
        else if (in_tag == r_window_tag)     in_pool = POOL_WINDOW;
        else if (in_tag == r_group_tag)      in_pool = POOL_GROUP;
        else                                 in_hit  = 1'b0;
    end

    always_comb begin
        unique case (r_pool)
            POOL_SPRITE: pool_tag = r_sprite_tag;
            POOL_WINDOW: pool_tag = r_window_tag;
            POOL_GROUP:  pool_tag = r_group_tag;
            default:     pool_tag = r_sprite_tag;
        endcase
    end

    assign idx       = r_handle[C_IDX_W-1:0];
    assign screen    = (r_handle == '0);
    assign full      = C_SIZE_W'(r_count[r_pool]) >= P_SIZE[r_pool];
    assign range_bad = {1'b0, idx} >= P_SIZE[r_pool];

    always_comb begin
        dec_status        = STS_OK;
        dec_pool          = POOL_SPRITE;
        o_stat.go_scan    = 1'b0;
        o_stat.go_access  = 1'b0;
        o_stat.go_clear   = 1'b0;
        o_stat.scan_found = scan_found;
        o_stat.clear_last = clear_last;
        o_stat.out_free   = out_free;
        unique case (r_op)
            OP_CREATE: begin
                if (!r_hit) begin
                    dec_status = STS_UNKNOWN;
                end else begin
                    dec_pool = r_pool;
                    if (full) dec_status = STS_FULL;
                    else      o_stat.go_scan = 1'b1;
                end
            end
            OP_DESTROY, OP_RESOLVE: begin
                if (screen) begin
                    dec_status = STS_OK;
                end else if (!r_hit) begin
                    dec_status = STS_UNKNOWN;
                end else begin
                    dec_pool = r_pool;
                    if (range_bad) dec_status = STS_FULL;
                    else           o_stat.go_access = 1'b1;
                end
            end
            OP_CLEAR: begin
                o_stat.go_clear = 1'b1;
            end
            default: begin
                dec_status = STS_OK;
            end
        endcase
    end

    // read addressing: decode issues the first word, scan walks forward
    always_comb begin
        if (i_cmd.scan) rd_widx = r_word + 1'b1;
        else if (r_op == OP_CREATE) rd_widx = r_hint[r_pool];
        else rd_widx = idx[C_IDX_W-1:C_BIT_W];
    end

    assign occ_raddr = P_WBASE[r_pool] + WAW'(rd_widx);
    assign ser_raddr = P_SBASE[r_pool] + SAW'(idx);

    // bits past the pool's last slot count as taken
    assign word_mask  = (r_word == P_LASTW[r_pool]) ? P_LMASK[r_pool] : '1;
    assign eff_word   = r_occ_rd | ~word_mask;
    assign scan_found = ~&eff_word;
    assign free_bit   = lowest_zero(eff_word);
    assign free_slot  = {r_word, free_bit};
    assign slot_used  = r_occ_rd[idx[C_BIT_W-1:0]];

    assign scan_commit    = i_cmd.scan && scan_found;
    assign destroy_commit = i_cmd.access && slot_used && (r_op == OP_DESTROY);

    assign wbit        = i_cmd.scan ? free_bit : idx[C_BIT_W-1:0];
    assign wbit_onehot = {{(C_WORD_BITS-1){1'b0}}, 1'b1} << wbit;
    assign occ_we      = i_cmd.clear || scan_commit || destroy_commit;
    assign occ_waddr   = i_cmd.clear ? r_clr : P_WBASE[r_pool] + WAW'(r_word);

    always_comb begin
        if (i_cmd.clear)      occ_wdata = '0;
        else if (scan_commit) occ_wdata = r_occ_rd | wbit_onehot;
        else                  occ_wdata = r_occ_rd & ~wbit_onehot;
    end

    assign clear_last = (r_clr == WAW'(TOTAL_WORDS - 1));
    assign out_free   = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
        r_occ_rd <= occ_mem[occ_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (scan_commit) ser_mem[P_SBASE[r_pool] + SAW'(free_slot)] <= r_next[r_pool];
        r_ser_rd <= ser_mem[ser_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_tag <= C_SPRITE_TAG_RST;
            r_window_tag <= C_WINDOW_TAG_RST;
            r_group_tag  <= C_GROUP_TAG_RST;
            r_count      <= '0;
            r_next       <= '0;
            r_hint       <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SPRITE_TAG: r_sprite_tag <= i_cfg_data;
                    REG_WINDOW_TAG: r_window_tag <= i_cfg_data;
                    REG_GROUP_TAG:  r_group_tag  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.decode && (r_op == OP_CLEAR)) begin
                r_count <= '0;
                r_hint  <= '0;
            end
            if (i_cmd.clear) begin
                r_clr <= clear_last ? '0 : r_clr + 1'b1;
            end
            if (scan_commit) begin
                r_next[r_pool]  <= r_next[r_pool] + 1'b1;
                r_count[r_pool] <= r_count[r_pool] + 1'b1;
                r_hint[r_pool]  <= r_word;
            end
            if (destroy_commit) begin
                r_count[r_pool] <= r_count[r_pool] - 1'b1;
                if (r_word < r_hint[r_pool]) r_hint[r_pool] <= r_word;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op     <= t_opcode'(i_opcode);
            r_handle <= i_handle;
            r_pool   <= in_pool;
            r_hit    <= in_hit;
        end
        if (i_cmd.decode) begin
            r_word       <= rd_widx;
            r_res_status <= dec_status;
            r_res_pool   <= dec_pool;
            r_res_screen <= screen && (r_op == OP_RESOLVE);
            r_res_newh   <= '0;
            r_res_slot   <= '0;
            r_res_serial <= '0;
        end
        if (i_cmd.scan) begin
            if (scan_found) begin
                r_res_slot   <= free_slot[C_SLOT_OUT_W-1:0];
                r_res_serial <= r_next[r_pool];
                r_res_newh   <= {pool_tag, free_slot};
            end else begin
                r_word <= rd_widx;
            end
        end
        if (i_cmd.access) begin
            r_res_slot <= idx[C_SLOT_OUT_W-1:0];
            if (slot_used) r_res_serial <= r_ser_rd;
            else           r_res_status <= STS_EMPTY;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_newh   <= r_res_newh;
            r_out_screen <= r_res_screen;
            r_out_pool   <= r_res_pool;
            r_out_slot   <= r_res_slot;
            r_out_serial <= r_res_serial;
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_new_handle  = r_out_newh;
    assign o_is_screen   = r_out_screen;
    assign o_pool        = r_out_pool;
    assign o_slot_index  = r_out_slot;
    assign o_slot_serial = r_out_serial;

    `THSA_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, (C_SIZE_W'(r_count[POOL_SPRITE]) <= P_SIZE[POOL_SPRITE]) && (C_SIZE_W'(r_count[POOL_WINDOW]) <= P_SIZE[POOL_WINDOW]) && (C_SIZE_W'(r_count[POOL_GROUP]) <= P_SIZE[POOL_GROUP]), "live count above pool size")
    `THSA_ASSERT_NEXT(a_serial_step, i_clk, i_rst_n, scan_commit, r_next[r_pool] == $past(r_next[r_pool]) + 32'd1, "pool serial not advanced on create")

endmodule

### test/tb_tagged_handle_slot_allocator.sv
// ----------------------------------------------------------------------------
// Tagged handle slot allocator testbench
// Drives create, destroy, resolve and clear-all requests under random idling
// on both channels. A local model of the three pools predicts every response,
// and each response is checked field by field against the oldest prediction.
// Tag registers are rewritten between phases, including overlapping tags and
// the 0 and 255 extremes. The window and group pools are filled to the full
// condition.
// ----------------------------------------------------------------------------
module tb_tagged_handle_slot_allocator;
    import thsa_pkg::*;

    localparam int MAX_SLOTS = 512;

    typedef struct packed {
        t_status     status;
        logic [31:0] new_handle;
        logic        is_screen;
        t_pool       pool;
        logic [8:0]  slot_index;
        logic [31:0] slot_serial;
    } alloc_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    thsa_req_if req_if ();
    thsa_rsp_if rsp_if ();
    thsa_cfg_if cfg_if ();

    tagged_handle_slot_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // pool model
    bit          slot_used [C_POOLS][MAX_SLOTS];
    logic [31:0] slot_stamp [C_POOLS][MAX_SLOTS];
    int          live_count [C_POOLS];
    logic [31:0] next_serial [C_POOLS];
    logic [7:0]  pool_tag [C_POOLS];

    alloc_result_t pending_results [$];
    logic [31:0]   live_handles [$];
    int            error_count = 0;
    bit            steady = 1'b0;

    function automatic int pool_size(int p);
        case (p)
            0:       return 512;
            1:       return 64;
            default: return 64;
        endcase
    endfunction

    function automatic int find_pool(logic [7:0] tag);
        for (int p = 0; p < C_POOLS; p++)
            if (pool_tag[p] == tag) return p;
        return C_POOLS;
    endfunction

    function automatic alloc_result_t predict_alloc_result(t_opcode op, logic [7:0] kind,
                                                           logic [31:0] handle);
        alloc_result_t r;
        int p;
        int idx;
        r = '0;
        case (op)
            OP_CREATE: begin
                p = find_pool(kind);
                if (p == C_POOLS) begin
                    r.status = STS_UNKNOWN;
                end else begin
                    r.pool = t_pool'(p);
                    idx = 0;
                    while (idx < pool_size(p) && slot_used[p][idx]) idx++;
                    if (live_count[p] >= pool_size(p) || idx >= pool_size(p)) begin
                        r.status = STS_FULL;
                    end else begin
                        slot_used[p][idx] = 1'b1;
                        slot_stamp[p][idx] = next_serial[p];
                        r.slot_serial = next_serial[p];
                        next_serial[p] = next_serial[p] + 32'd1;
                        live_count[p]++;
                        r.slot_index = idx[8:0];
                        r.new_handle = {pool_tag[p], idx[23:0]};
                    end
                end
            end
            OP_DESTROY, OP_RESOLVE: begin
                if (handle == 32'd0) begin
                    r.is_screen = (op == OP_RESOLVE);
                end else begin
                    p = find_pool(handle[31:24]);
                    if (p == C_POOLS) begin
                        r.status = STS_UNKNOWN;
                    end else begin
                        r.pool = t_pool'(p);
                        idx = int'(handle[23:0]);
                        if (idx >= pool_size(p)) begin
                            r.status = STS_FULL;
                        end else if (!slot_used[p][idx]) begin
                            r.status = STS_EMPTY;
                            r.slot_index = idx[8:0];
                        end else begin
                            r.slot_index = idx[8:0];
                            r.slot_serial = slot_stamp[p][idx];
                            if (op == OP_DESTROY) begin
                                slot_used[p][idx] = 1'b0;
                                if (live_count[p] > 0) live_count[p]--;
                            end
                        end
                    end
                end
            end
            default: begin
                for (int q = 0; q < C_POOLS; q++) begin
                    live_count[q] = 0;
                    for (int s = 0; s < MAX_SLOTS; s++) slot_used[q][s] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_live(bit remove);
        int k;
        logic [31:0] h;
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        if (remove) live_handles.delete(k);
        return h;
    endfunction

    function automatic logic [31:0] noise_handle();
        logic [7:0] tag;
        tag = pool_tag[$urandom_range(0, C_POOLS - 1)];
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return {tag, 24'($urandom_range(0, 600))};
            2:       return 32'd0;
            default: return {tag, 24'($urandom_range(0, 63))};
        endcase
    endfunction

    task automatic send_request(t_opcode op, logic [7:0] kind, logic [31:0] handle);
        int gap;
        alloc_result_t r;
        gap = steady ? 0 : random_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.opcode   = op;
        req_if.kind_tag = kind;
        req_if.handle   = handle;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        r = predict_alloc_result(op, kind, handle);
        pending_results.push_back(r);
        if (op == OP_CREATE && r.status == STS_OK) live_handles.push_back(r.new_handle);
        if (op == OP_CLEAR) live_handles.delete();
    endtask

    task automatic create(logic [7:0] kind);
        send_request(OP_CREATE, kind, $urandom());
    endtask

    task automatic on_handle(t_opcode op, logic [31:0] handle);
        send_request(op, 8'($urandom_range(0, 255)), handle);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tag(t_cfg_reg idx, logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        pool_tag[idx] = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_tags(logic [7:0] s, logic [7:0] w, logic [7:0] g);
        drain_results();
        write_tag(REG_SPRITE_TAG, s);
        write_tag(REG_WINDOW_TAG, w);
        write_tag(REG_GROUP_TAG, g);
    endtask

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) report_mismatch(what, exp_v, act_v);
    endtask

    // response ready with random stalls
    initial begin : rsp_backpressure
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = random_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_responses
        alloc_result_t r;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected response", 32'd0, {30'd0, rsp_if.status});
            end else begin
                r = pending_results.pop_front();
                check_field("status", 32'(r.status), 32'(rsp_if.status));
                check_field("new_handle", r.new_handle, rsp_if.new_handle);
                check_field("is_screen", 32'(r.is_screen), 32'(rsp_if.is_screen));
                check_field("pool", 32'(r.pool), 32'(rsp_if.pool));
                check_field("slot_index", 32'(r.slot_index), 32'(rsp_if.slot_index));
                check_field("slot_serial", r.slot_serial, rsp_if.slot_serial);
            end
        end
    end

    // reset tags: every opcode and each error status
    task automatic test_basic_ops();
        on_handle(OP_RESOLVE, 32'h0000_0000);
        on_handle(OP_DESTROY, 32'h0000_0000);
        create(8'd128);
        create(8'd129);
        create(8'd130);
        create(8'd128);
        create(8'h00);
        create(8'hFF);
        on_handle(OP_RESOLVE, 32'h8000_0001);
        on_handle(OP_RESOLVE, 32'h8100_0000);
        on_handle(OP_RESOLVE, 32'h8200_0000);
        on_handle(OP_RESOLVE, 32'h8100_0040);
        on_handle(OP_DESTROY, 32'h80FF_FFFF);
        on_handle(OP_RESOLVE, 32'h8000_0005);
        on_handle(OP_DESTROY, 32'h8200_0003);
        on_handle(OP_RESOLVE, 32'h7F00_0001);
        on_handle(OP_DESTROY, 32'h8000_0000);
        on_handle(OP_RESOLVE, 32'h8000_0000);
        create(8'd128);
        on_handle(OP_RESOLVE, 32'h8000_01FF);
        on_handle(OP_CLEAR, $urandom());
        on_handle(OP_RESOLVE, 32'h8000_0001);
        create(8'd129);
        on_handle(OP_DESTROY, 32'hFFFF_FFFF);
    endtask

    // equal tags: lowest pool wins, handle zero stays the screen
    task automatic test_overlapping_tags();
        set_tags(8'h00, 8'h00, 8'h00);
        on_handle(OP_CLEAR, $urandom());
        create(8'h00);
        create(8'h00);
        on_handle(OP_RESOLVE, 32'h0000_0000);
        on_handle(OP_DESTROY, 32'h0000_0000);
        on_handle(OP_RESOLVE, 32'h0000_0001);
        set_tags(8'hFF, 8'hFF, 8'hFF);
        create(8'hFF);
        on_handle(OP_RESOLVE, 32'hFF00_0000);
        on_handle(OP_RESOLVE, 32'h0000_0001);
        set_tags(8'hC8, 8'h07, 8'h07);
        create(8'h07);
        on_handle(OP_RESOLVE, 32'h0700_0000);
        create(8'hC8);
    endtask

    // fill the group and window pools past full, free a few slots and refill
    task automatic test_pool_full();
        int p;
        set_tags(8'h10, 8'h20, 8'h30);
        on_handle(OP_CLEAR, $urandom());
        for (int n = 2; n >= 1; n--) begin
            p = n;
            repeat (pool_size(p) + 1) create(pool_tag[p]);
            repeat (3) on_handle(OP_DESTROY, pick_live(1'b1));
            repeat (4) create(pool_tag[p]);
        end
    endtask

    task automatic random_phase(int count);
        int r;
        on_handle(OP_CLEAR, $urandom());
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 99) < 85) create(pool_tag[$urandom_range(0, C_POOLS - 1)]);
                else create(8'($urandom_range(0, 255)));
            end else if (r < 65 && live_handles.size() != 0) begin
                on_handle(OP_DESTROY, pick_live(1'b1));
            end else if (r < 78 && live_handles.size() != 0) begin
                on_handle(OP_RESOLVE, pick_live(1'b0));
            end else if (r < 98) begin
                on_handle(($urandom_range(0, 1) == 0) ? OP_DESTROY : OP_RESOLVE, noise_handle());
            end else begin
                on_handle(OP_CLEAR, $urandom());
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        set_tags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
        random_phase(140);
        set_tags(8'h00, 8'hFF, 8'h00);
        random_phase(130);
        set_tags(C_SPRITE_TAG_RST, C_WINDOW_TAG_RST, C_GROUP_TAG_RST);
        random_phase(140);
    endtask

    initial begin
        for (int q = 0; q < C_POOLS; q++) begin
            live_count[q]  = 0;
            next_serial[q] = 32'd0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                slot_used[q][s]  = 1'b0;
                slot_stamp[q][s] = 32'd0;
            end
        end
        pool_tag[0] = C_SPRITE_TAG_RST;
        pool_tag[1] = C_WINDOW_TAG_RST;
        pool_tag[2] = C_GROUP_TAG_RST;

        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_CREATE;
        req_if.kind_tag = 8'd0;
        req_if.handle   = 32'd0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_SPRITE_TAG;
        cfg_if.data     = 8'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_overlapping_tags();
        test_pool_full();
        test_random_traffic();

        drain_results();
        repeat (30) @(posedge i_clk);
        if (error_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
